/* sv/tsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared constants, codes and types of the thermometer conversion pipeline.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int FRAC_BITS       = 8;
  localparam int OUT_W           = 24;
  localparam int NUM_W           = 8 + FRAC_BITS;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = (NUM_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DIV_W           = DIV_STAGES * STEPS_PER_STAGE;
  localparam int SUM_W           = 18 + FRAC_BITS;

  localparam logic [7:0] FAM_A  = 8'h28;
  localparam logic [7:0] FAM_B  = 8'h22;
  localparam logic [7:0] FAM_S  = 8'h10;
  localparam logic [7:0] RES_9  = 8'h1F;
  localparam logic [7:0] RES_10 = 8'h3F;
  localparam logic [7:0] RES_11 = 8'h5F;
  localparam logic [7:0] RES_12 = 8'h7F;

  localparam logic signed [SUM_W-1:0] ERR_BASE = -(SUM_W'(127) <<< FRAC_BITS);
  localparam logic signed [SUM_W-1:0] QUARTER  = SUM_W'(1) <<< (FRAC_BITS - 2);
  localparam logic signed [SUM_W-1:0] SAT_HI   = SUM_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO   = -(SUM_W'(1) <<< (OUT_W - 1));

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FAMILY     = 2'd1,
    ST_RESOLUTION = 2'd2,
    ST_ZERO_DIV   = 2'd3
  } st_t;

  typedef struct packed {
    st_t                      status;
    logic                     use_frac;
    logic                     neg;
    logic signed [SUM_W-1:0]  base;
  } side_t;

endpackage
`default_nettype wire

/* sv/tsc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_div
// Pipelined restoring divider, a few quotient bits per stage, with sideband.
// ----------------------------------------------------------------------------
module tsc_div
  import tsc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [NUM_W-1:0] in_num,
  input  wire logic [7:0]       in_den,
  input  wire side_t            in_side,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [DIV_W-1:0]      out_quo,
  output side_t                 out_side
);

  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES:0]   rdy;
  logic [DIV_W-1:0]      acc_r  [DIV_STAGES];
  logic [7:0]            rem_r  [DIV_STAGES];
  logic [7:0]            den_r  [DIV_STAGES];
  side_t                 side_r [DIV_STAGES];

  logic [DIV_STAGES-1:0] src_v;
  logic [DIV_W-1:0]      src_acc  [DIV_STAGES];
  logic [7:0]            src_rem  [DIV_STAGES];
  logic [7:0]            src_den  [DIV_STAGES];
  side_t                 src_side [DIV_STAGES];
  logic [DIV_W-1:0]      acc_nxt  [DIV_STAGES];
  logic [7:0]            rem_nxt  [DIV_STAGES];

  assign rdy[DIV_STAGES] = out_ready;
  assign in_ready        = rdy[0];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign src_v[g]    = in_valid;
      assign src_acc[g]  = DIV_W'(in_num);
      assign src_rem[g]  = '0;
      assign src_den[g]  = in_den;
      assign src_side[g] = in_side;
    end else begin : g_next
      assign src_v[g]    = v_r[g-1];
      assign src_acc[g]  = acc_r[g-1];
      assign src_rem[g]  = rem_r[g-1];
      assign src_den[g]  = den_r[g-1];
      assign src_side[g] = side_r[g-1];
    end

    assign rdy[g] = !v_r[g] || rdy[g+1];

    always_comb begin
      logic [8:0]       trial;
      logic [7:0]       rem_w;
      logic [DIV_W-1:0] acc_w;
      rem_w = src_rem[g];
      acc_w = src_acc[g];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        trial = {rem_w, acc_w[DIV_W-1]};
        if (trial >= {1'b0, src_den[g]}) begin
          trial = trial - {1'b0, src_den[g]};
          acc_w = {acc_w[DIV_W-2:0], 1'b1};
        end else begin
          acc_w = {acc_w[DIV_W-2:0], 1'b0};
        end
        rem_w = trial[7:0];
      end
      rem_nxt[g] = rem_w;
      acc_nxt[g] = acc_w;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (rdy[g]) begin
        v_r[g] <= src_v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        acc_r[g]  <= acc_nxt[g];
        rem_r[g]  <= rem_nxt[g];
        den_r[g]  <= src_den[g];
        side_r[g] <= src_side[g];
      end
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_quo   = acc_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule
`default_nettype wire

/* sv/thermometer_scratchpad_to_celsius.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thermometer_scratchpad_to_celsius
// Converts a thermometer scratchpad reading to signed Q8 degrees plus status.
// Pipeline: decode register, DIV_STAGES divider stages, then the sum/saturate output register.
// Throughput: one request per cycle while the output is not stalled; the pipelined divider stages set it.
// Stalls back-propagate stage by stage, so empty stages still take requests.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
module thermometer_scratchpad_to_celsius
  import tsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] family_code, [23:8] raw_temperature, [31:24] resolution_byte,
  // [39:32] remain_count, [47:40] count_per_degree
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [23:0] temperature_q8, [25:24] status, [31:26] zero
  output logic [31:0]      out_tdata
);

  logic [7:0]         family_code;
  logic signed [15:0] raw_temperature;
  logic [7:0]         resolution_byte;
  logic [7:0]         remain_count;
  logic [7:0]         count_per_degree;

  assign family_code      = in_tdata[7:0];
  assign raw_temperature  = in_tdata[23:8];
  assign resolution_byte  = in_tdata[31:24];
  assign remain_count     = in_tdata[39:32];
  assign count_per_degree = in_tdata[47:40];

  // decode stage
  logic             dec_v_r;
  side_t            dec_side_r, dec_side_nxt;
  logic [NUM_W-1:0] dec_num_r, dec_num_nxt;
  logic [7:0]       dec_den_r;
  logic             dec_rdy;
  logic             div_in_ready;

  always_comb begin
    logic signed [SUM_W-1:0] raw_ext;
    logic [1:0]              drop;
    logic                    res_ok;
    logic [7:0]              mag;
    raw_ext = SUM_W'(raw_temperature);
    drop    = 2'd0;
    res_ok  = 1'b1;
    mag     = '0;
    case (resolution_byte)
      RES_12:  drop = 2'd0;
      RES_11:  drop = 2'd1;
      RES_10:  drop = 2'd2;
      RES_9:   drop = 2'd3;
      default: res_ok = 1'b0;
    endcase
    dec_side_nxt.status   = ST_FAMILY;
    dec_side_nxt.use_frac = 1'b0;
    dec_side_nxt.neg      = 1'b0;
    dec_side_nxt.base     = ERR_BASE;
    dec_num_nxt           = '0;
    if (family_code inside {FAM_A, FAM_B}) begin
      if (res_ok) begin
        dec_side_nxt.status = ST_OK;
        dec_side_nxt.base   = ((raw_ext >>> drop) <<< drop) <<< (FRAC_BITS - 4);
      end else begin
        dec_side_nxt.status = ST_RESOLUTION;
      end
    end else if (family_code == FAM_S) begin
      if (count_per_degree == 8'd0) begin
        dec_side_nxt.status = ST_ZERO_DIV;
      end else begin
        dec_side_nxt.status   = ST_OK;
        dec_side_nxt.use_frac = 1'b1;
        dec_side_nxt.neg      = remain_count > count_per_degree;
        mag = dec_side_nxt.neg ? (remain_count - count_per_degree)
                               : (count_per_degree - remain_count);
        dec_num_nxt       = {mag, {FRAC_BITS{1'b0}}};
        dec_side_nxt.base = ((raw_ext >>> 1) <<< FRAC_BITS) - QUARTER;
      end
    end
  end

  assign dec_rdy   = !dec_v_r || div_in_ready;
  assign in_tready = dec_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_v_r <= 1'b0;
    end else if (dec_rdy) begin
      dec_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_rdy) begin
      dec_side_r <= dec_side_nxt;
      dec_num_r  <= dec_num_nxt;
      dec_den_r  <= count_per_degree;
    end
  end

  // divider
  logic             div_out_valid;
  logic             div_out_ready;
  logic [DIV_W-1:0] div_quo;
  side_t            div_side;

  tsc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dec_v_r),
    .in_ready  (div_in_ready),
    .in_num    (dec_num_r),
    .in_den    (dec_den_r),
    .in_side   (dec_side_r),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // sum, saturate, output register
  logic                 out_v_r;
  logic [OUT_W-1:0]     temp_r, temp_nxt;
  st_t                  status_r;

  always_comb begin
    logic signed [SUM_W-1:0] q_ext;
    logic signed [SUM_W-1:0] sum;
    q_ext = SUM_W'(div_quo);
    if (div_side.neg) begin
      q_ext = -q_ext;
    end
    sum = div_side.base + (div_side.use_frac ? q_ext : SUM_W'(0));
    if (sum > SAT_HI) begin
      temp_nxt = SAT_HI[OUT_W-1:0];
    end else if (sum < SAT_LO) begin
      temp_nxt = SAT_LO[OUT_W-1:0];
    end else begin
      temp_nxt = sum[OUT_W-1:0];
    end
  end

  assign div_out_ready = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (div_out_ready) begin
      out_v_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_out_ready) begin
      temp_r   <= temp_nxt;
      status_r <= div_side.status;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, status_r, temp_r};

endmodule
`default_nettype wire

/* tb/sv/thermometer_scratchpad_to_celsius_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermometer_scratchpad_to_celsius_test
// Drives thermometer readings into the converter and checks each converted
// temperature and status against an in-bench conversion, in order. Directed
// readings cover every family rule, resolution code and error case; random
// readings follow, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module thermometer_scratchpad_to_celsius_test;
  import tsc_pkg::*;

  localparam int RANDOM_READINGS = 500;
  localparam int STALL_LIMIT     = 1000;
  localparam int HOLD_CYCLES     = 60;

  class conversion_board;
    typedef struct {
      logic signed [OUT_W-1:0] temp;
      st_t                     status;
    } reading_t;

    reading_t expected_q[$];
    int       errors;
    int       accepted;
    int       received;

    function reading_t convert(logic [47:0] d);
      logic [7:0]         fam;
      logic [7:0]         res;
      logic signed [15:0] raw;
      longint             r;
      longint             remain;
      longint             per;
      longint             one;
      longint             t;
      int                 drop;
      reading_t           x;
      fam    = d[7:0];
      raw    = d[23:8];
      res    = d[31:24];
      remain = d[39:32];
      per    = d[47:40];
      r      = raw;
      one    = longint'(1) << FRAC_BITS;
      t      = -127 * one;
      x.status = ST_OK;
      if (fam == FAM_A || fam == FAM_B) begin
        case (res)
          RES_12:  drop = 0;
          RES_11:  drop = 1;
          RES_10:  drop = 2;
          RES_9:   drop = 3;
          default: drop = 4;
        endcase
        if (drop > 3) begin
          x.status = ST_RESOLUTION;
        end else begin
          t = (r >>> drop) * (longint'(1) << drop) * (longint'(1) << (FRAC_BITS - 4));
        end
      end else if (fam == FAM_S) begin
        if (per == 0) begin
          x.status = ST_ZERO_DIV;
        end else begin
          t = (r >>> 1) * one - (longint'(1) << (FRAC_BITS - 2)) + ((per - remain) * one) / per;
        end
      end else begin
        x.status = ST_FAMILY;
      end
      if (t > (longint'(1) << (OUT_W - 1)) - 1) t = (longint'(1) << (OUT_W - 1)) - 1;
      if (t < -(longint'(1) << (OUT_W - 1))) t = -(longint'(1) << (OUT_W - 1));
      x.temp = t[OUT_W-1:0];
      return x;
    endfunction

    function void note_request(logic [47:0] d);
      expected_q.push_back(convert(d));
      accepted++;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [31:0] d);
      reading_t x;
      received++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", d));
      end else begin
        x = expected_q.pop_front();
        if (d[OUT_W-1:0] !== x.temp)
          report($sformatf("temperature %h, want %h", d[OUT_W-1:0], x.temp));
        if (d[25:24] !== x.status)
          report($sformatf("status %0d, want %0d", d[25:24], x.status));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  conversion_board board = new;
  int  stall_cycles = 0;
  int  hold_cnt     = 0;
  bit  hold_done    = 1'b0;

  thermometer_scratchpad_to_celsius DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [47:0] pack_reading(logic [7:0] fam, logic [15:0] raw,
                                               logic [7:0] res, logic [7:0] remain,
                                               logic [7:0] per);
    return {per, remain, res, raw, fam};
  endfunction

  function automatic logic [47:0] random_reading();
    logic [7:0] fam;
    logic [7:0] res;
    logic [7:0] per;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 35)      fam = FAM_A;
    else if (pick < 60) fam = FAM_B;
    else if (pick < 85) fam = FAM_S;
    else                fam = 8'($urandom);
    case ($urandom_range(9))
      0:       res = RES_9;
      1, 2:    res = RES_10;
      3, 4:    res = RES_11;
      5, 6, 7: res = RES_12;
      default: res = 8'($urandom);
    endcase
    pick = $urandom_range(99);
    if (pick < 8)       per = 8'd0;
    else if (pick < 50) per = 8'd16;
    else                per = 8'($urandom);
    return pack_reading(fam, 16'($urandom), res, 8'($urandom), per);
  endfunction

  task automatic send_request(input logic [47:0] d, input bit may_idle);
    while (may_idle && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(d);
  endtask

  // output side: random backpressure, one long hold-off, one calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt - 1;
    end else if (!hold_done && board.accepted >= 120) begin
      out_tready <= 1'b0;
      hold_cnt   <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else if (board.received >= 320 && board.received < 420) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 12/11/10/9-bit families, extremes of the raw word
    send_request(pack_reading(FAM_A, 16'h0550, RES_12, 8'h00, 8'h00), 1'b0);
    send_request(pack_reading(FAM_A, 16'h8000, RES_11, 8'hFF, 8'hFF), 1'b0);
    send_request(pack_reading(FAM_A, 16'h7FFF, RES_10, 8'h0C, 8'h10), 1'b0);
    send_request(pack_reading(FAM_A, 16'hFFFF, RES_9,  8'hA5, 8'h5A), 1'b0);
    send_request(pack_reading(FAM_B, 16'hFC90, RES_12, 8'h33, 8'h00), 1'b0);
    send_request(pack_reading(FAM_B, 16'h7FFF, RES_9,  8'h00, 8'h00), 1'b0);
    send_request(pack_reading(FAM_B, 16'h8000, RES_10, 8'hFF, 8'h00), 1'b0);
    send_request(pack_reading(FAM_B, 16'h00AA, RES_11, 8'h01, 8'h02), 1'b0);
    // unknown resolution codes
    send_request(pack_reading(FAM_A, 16'h0064, 8'h00, 8'h00, 8'h10), 1'b0);
    send_request(pack_reading(FAM_B, 16'h0064, 8'hFF, 8'h00, 8'h10), 1'b0);
    send_request(pack_reading(FAM_A, 16'h0064, 8'h7E, 8'h00, 8'h10), 1'b0);
    // extended-resolution family, remain above per, zero per
    send_request(pack_reading(FAM_S, 16'h0032, 8'h00, 8'h0C, 8'h10), 1'b0);
    send_request(pack_reading(FAM_S, 16'h8000, 8'hFF, 8'h00, 8'hFF), 1'b0);
    send_request(pack_reading(FAM_S, 16'h7FFF, RES_12, 8'hFF, 8'h01), 1'b0);
    send_request(pack_reading(FAM_S, 16'hFFFF, 8'h55, 8'hFF, 8'hFF), 1'b0);
    send_request(pack_reading(FAM_S, 16'h0000, 8'hAA, 8'hC8, 8'h03), 1'b0);
    send_request(pack_reading(FAM_S, 16'h0005, 8'h00, 8'h07, 8'h00), 1'b0);
    send_request(pack_reading(FAM_S, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0);
    // unknown families
    send_request(pack_reading(8'h00, 16'h1234, RES_12, 8'h0C, 8'h10), 1'b0);
    send_request(pack_reading(8'hFF, 16'hEDCB, RES_9,  8'hF0, 8'h0F), 1'b0);
    send_request(pack_reading(8'h29, 16'h0550, RES_12, 8'h00, 8'h10), 1'b0);
    send_request(pack_reading(8'h11, 16'h0032, RES_12, 8'h0C, 8'h10), 1'b0);

    for (int i = 0; i < RANDOM_READINGS; i++) begin
      send_request(random_reading(), !(i >= 150 && i < 300));
    end
    in_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
